FILE: design/cmdp_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the command line parser
// no dependencies; used by every module of the block

package cmdp_pkg;

  // default accumulator width for decimal numbers
  localparam int unsigned VALUE_BITS_DEF = 32;

  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned TAG_W   = 3;
  localparam int unsigned USAGE_W = 2;
  localparam int unsigned OUT_W   = 32;

  // result tags
  localparam logic [TAG_W-1:0] TAG_NONE    = 3'd0;
  localparam logic [TAG_W-1:0] TAG_INVALID = 3'd1;
  localparam logic [TAG_W-1:0] TAG_SPEED   = 3'd2;
  localparam logic [TAG_W-1:0] TAG_REV     = 3'd3;
  localparam logic [TAG_W-1:0] TAG_SWITCH  = 3'd4;
  localparam logic [TAG_W-1:0] TAG_QUIT    = 3'd5;

  // command kinds, also the usage code of an invalid line
  localparam logic [USAGE_W-1:0] KIND_TR = 2'd0;
  localparam logic [USAGE_W-1:0] KIND_RV = 2'd1;
  localparam logic [USAGE_W-1:0] KIND_SW = 2'd2;
  localparam logic [USAGE_W-1:0] KIND_Q  = 2'd3;

  // characters
  localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
  localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_T     = 8'h74;
  localparam logic [CHAR_W-1:0] CH_R     = 8'h72;
  localparam logic [CHAR_W-1:0] CH_V     = 8'h76;
  localparam logic [CHAR_W-1:0] CH_S     = 8'h73;
  localparam logic [CHAR_W-1:0] CH_W     = 8'h77;
  localparam logic [CHAR_W-1:0] CH_Q     = 8'h71;
  localparam logic [CHAR_W-1:0] CH_UP_S  = 8'h53;
  localparam logic [CHAR_W-1:0] CH_UP_C  = 8'h43;
  localparam logic [CHAR_W-1:0] CH_C     = 8'h63;

  typedef struct packed {
    logic [CHAR_W-1:0] char_byte;
    logic              is_end;
  } char_item_t;

  typedef struct packed {
    logic [TAG_W-1:0]   cmd_tag;
    logic [USAGE_W-1:0] usage_code;
    logic [OUT_W-1:0]   first_value;
    logic [OUT_W-1:0]   second_value;
    logic               straight;
  } result_item_t;

endpackage

FILE: design/cmdp_parser.sv
`timescale 1ns / 1ps
// parse state machine: phase, number accumulators, direction and command kind
// depends on cmdp_pkg; steps once per character transfer, builds the result at end of line

module cmdp_parser #(
  parameter int unsigned VALUE_BITS = cmdp_pkg::VALUE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   step,
  input  cmdp_pkg::char_item_t   item,
  output cmdp_pkg::result_item_t result
);

  typedef enum logic [3:0] {
    PH_LEAD, PH_T1, PH_R1, PH_S1, PH_NUM1W, PH_NUM1, PH_NUM2W, PH_NUM2,
    PH_DIRW, PH_TAIL, PH_BAD, PH_NONE
  } phase_t;

  phase_t                         phase, phase_next;
  logic [VALUE_BITS-1:0]          first_acc, first_acc_next;
  logic [VALUE_BITS-1:0]          second_acc, second_acc_next;
  logic                           dir_flag, dir_flag_next;
  logic [cmdp_pkg::USAGE_W-1:0]   kind, kind_next;

  logic [cmdp_pkg::CHAR_W-1:0]    c;
  logic                           is_digit, is_space, is_dir, dir_val;
  logic [VALUE_BITS-1:0]          digit_val;
  logic [VALUE_BITS-1:0]          first_acc_ext, second_acc_ext;
  logic                           bad;

  assign c         = item.char_byte;
  assign is_digit  = (c >= cmdp_pkg::CH_0) && (c <= cmdp_pkg::CH_9);
  assign is_space  = (c == cmdp_pkg::CH_SPACE);
  assign is_dir    = (c == cmdp_pkg::CH_UP_S) || (c == cmdp_pkg::CH_S) ||
                     (c == cmdp_pkg::CH_UP_C) || (c == cmdp_pkg::CH_C);
  assign dir_val   = (c == cmdp_pkg::CH_UP_S) || (c == cmdp_pkg::CH_S);
  // low nibble of an ascii digit is its value
  assign digit_val = VALUE_BITS'(c[3:0]);

  // acc * 10 + digit as two shifts and adds, wrapping at the accumulator width
  assign first_acc_ext  = (first_acc << 3) + (first_acc << 1) + digit_val;
  assign second_acc_ext = (second_acc << 3) + (second_acc << 1) + digit_val;

  always_comb begin
    phase_next      = phase;
    first_acc_next  = first_acc;
    second_acc_next = second_acc;
    dir_flag_next   = dir_flag;
    kind_next       = kind;
    if (item.is_end) begin
      phase_next      = PH_LEAD;
      first_acc_next  = '0;
      second_acc_next = '0;
      dir_flag_next   = 1'b0;
      kind_next       = cmdp_pkg::KIND_TR;
    end else begin
      unique case (phase)
        PH_LEAD: begin
          if (is_space) begin
            phase_next = PH_LEAD;
          end else if (c == cmdp_pkg::CH_T) begin
            phase_next = PH_T1;
          end else if (c == cmdp_pkg::CH_R) begin
            phase_next = PH_R1;
          end else if (c == cmdp_pkg::CH_S) begin
            phase_next = PH_S1;
          end else if (c == cmdp_pkg::CH_Q) begin
            kind_next  = cmdp_pkg::KIND_Q;
            phase_next = PH_TAIL;
          end else begin
            phase_next = PH_NONE;
          end
        end
        PH_T1: begin
          if (c == cmdp_pkg::CH_R) begin
            kind_next  = cmdp_pkg::KIND_TR;
            phase_next = PH_NUM1W;
          end else begin
            phase_next = PH_NONE;
          end
        end
        PH_R1: begin
          if (c == cmdp_pkg::CH_V) begin
            kind_next  = cmdp_pkg::KIND_RV;
            phase_next = PH_NUM1W;
          end else begin
            phase_next = PH_NONE;
          end
        end
        PH_S1: begin
          if (c == cmdp_pkg::CH_W) begin
            kind_next  = cmdp_pkg::KIND_SW;
            phase_next = PH_NUM1W;
          end else begin
            phase_next = PH_NONE;
          end
        end
        PH_NUM1W: begin
          if (is_digit) begin
            first_acc_next = digit_val;
            phase_next     = PH_NUM1;
          end else if (!is_space) begin
            phase_next = PH_BAD;
          end
        end
        PH_NUM1: begin
          if (is_digit) begin
            first_acc_next = first_acc_ext;
          end else if (is_space) begin
            if (kind == cmdp_pkg::KIND_TR) begin
              phase_next = PH_NUM2W;
            end else if (kind == cmdp_pkg::KIND_SW) begin
              phase_next = PH_DIRW;
            end else begin
              phase_next = PH_TAIL;
            end
          end else if (kind == cmdp_pkg::KIND_SW && is_dir) begin
            // direction letter right after the switch number
            dir_flag_next = dir_val;
            phase_next    = PH_TAIL;
          end else begin
            phase_next = PH_BAD;
          end
        end
        PH_NUM2W: begin
          if (is_digit) begin
            second_acc_next = digit_val;
            phase_next      = PH_NUM2;
          end else if (!is_space) begin
            phase_next = PH_BAD;
          end
        end
        PH_NUM2: begin
          if (is_digit) begin
            second_acc_next = second_acc_ext;
          end else if (is_space) begin
            phase_next = PH_TAIL;
          end else begin
            phase_next = PH_BAD;
          end
        end
        PH_DIRW: begin
          if (is_dir) begin
            dir_flag_next = dir_val;
            phase_next    = PH_TAIL;
          end else if (!is_space) begin
            phase_next = PH_BAD;
          end
        end
        PH_TAIL: begin
          if (!is_space) begin
            phase_next = PH_BAD;
          end
        end
        PH_BAD: begin
          phase_next = PH_BAD;
        end
        default: begin
          phase_next = PH_NONE;
        end
      endcase
    end
  end

  // result of the line as it stands, taken when the end marker steps
  always_comb begin
    result = '0;
    bad    = 1'b0;
    unique case (phase)
      PH_NUM1W, PH_NUM2W, PH_DIRW, PH_BAD: begin
        bad = 1'b1;
      end
      PH_NUM1: begin
        if (kind == cmdp_pkg::KIND_RV) begin
          result.cmd_tag     = cmdp_pkg::TAG_REV;
          result.first_value = cmdp_pkg::OUT_W'(first_acc);
        end else begin
          bad = 1'b1;
        end
      end
      PH_NUM2: begin
        result.cmd_tag      = cmdp_pkg::TAG_SPEED;
        result.first_value  = cmdp_pkg::OUT_W'(first_acc);
        result.second_value = cmdp_pkg::OUT_W'(second_acc);
      end
      PH_TAIL: begin
        unique case (kind)
          cmdp_pkg::KIND_TR: begin
            result.cmd_tag      = cmdp_pkg::TAG_SPEED;
            result.first_value  = cmdp_pkg::OUT_W'(first_acc);
            result.second_value = cmdp_pkg::OUT_W'(second_acc);
          end
          cmdp_pkg::KIND_RV: begin
            result.cmd_tag     = cmdp_pkg::TAG_REV;
            result.first_value = cmdp_pkg::OUT_W'(first_acc);
          end
          cmdp_pkg::KIND_SW: begin
            result.cmd_tag     = cmdp_pkg::TAG_SWITCH;
            result.first_value = cmdp_pkg::OUT_W'(first_acc);
            result.straight    = dir_flag;
          end
          default: begin
            result.cmd_tag = cmdp_pkg::TAG_QUIT;
          end
        endcase
      end
      default: begin
        result.cmd_tag = cmdp_pkg::TAG_NONE;
      end
    endcase
    if (bad) begin
      result            = '0;
      result.cmd_tag    = cmdp_pkg::TAG_INVALID;
      result.usage_code = kind;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_LEAD;
      first_acc  <= '0;
      second_acc <= '0;
      dir_flag   <= 1'b0;
      kind       <= cmdp_pkg::KIND_TR;
    end else if (step) begin
      phase      <= phase_next;
      first_acc  <= first_acc_next;
      second_acc <= second_acc_next;
      dir_flag   <= dir_flag_next;
      kind       <= kind_next;
    end
  end

endmodule

FILE: design/cmdp_out_reg.sv
`timescale 1ns / 1ps
// result register driving the output channel
// depends on cmdp_pkg; holds one result until its transfer completes

module cmdp_out_reg (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   load,
  input  cmdp_pkg::result_item_t data,
  output logic                   open,
  output logic                   valid,
  input  logic                   stall,
  output cmdp_pkg::result_item_t item
);

  // free now, or emptied by a transfer at this edge
  assign open = !valid || !stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (!stall) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item <= data;
    end
  end

endmodule

FILE: design/command_line_parser.sv
`timescale 1ns / 1ps
// Command line parser. Takes one character per transfer on the char channel and, for each
// end-of-line item, gives one result on the result channel: tr with train and speed, rv with
// a train, sw with a switch and direction, q, invalid with the usage code of the command, or
// none. A new character is taken every cycle unless char_stall holds it. Each item passes
// an input register and then the parse state machine; an end-of-line result is loaded into
// the output register as its end marker leaves the input register. Characters keep
// flowing while a result waits; only an end marker held behind a stalled, full output
// register stalls the input. Numbers wrap modulo 2^VALUE_BITS and the low 32 bits are shown.
// Depends on cmdp_pkg, cmdp_parser and cmdp_out_reg.

module command_line_parser #(
  parameter int unsigned VALUE_BITS = cmdp_pkg::VALUE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   char_valid,
  output logic                   char_stall,
  input  cmdp_pkg::char_item_t   char_item,
  output logic                   result_valid,
  input  logic                   result_stall,
  output cmdp_pkg::result_item_t result_item
);

  logic                   hold_valid;
  cmdp_pkg::char_item_t   hold_item;
  logic                   hold_go;
  logic                   out_open;
  logic                   accept;
  cmdp_pkg::result_item_t line_result;

  // an end marker needs room in the output register, a character does not
  assign hold_go    = hold_valid && (!hold_item.is_end || out_open);
  assign char_stall = hold_valid && !hold_go;
  assign accept     = char_valid && !char_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (accept) begin
      hold_valid <= 1'b1;
    end else if (hold_go) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_item <= char_item;
    end
  end

  cmdp_parser #(
    .VALUE_BITS(VALUE_BITS)
  ) u_parser (
    .clk    (clk),
    .rst    (rst),
    .step   (hold_go),
    .item   (hold_item),
    .result (line_result)
  );

  cmdp_out_reg u_out_reg (
    .clk   (clk),
    .rst   (rst),
    .load  (hold_go && hold_item.is_end),
    .data  (line_result),
    .open  (out_open),
    .valid (result_valid),
    .stall (result_stall),
    .item  (result_item)
  );

endmodule

FILE: bench/tb_command_line_parser.sv
`timescale 1ns / 1ps
// testbench for command_line_parser: sends whole command lines one character per transfer
// and checks every end-of-line result against a line predictor kept here; uses cmdp_pkg

module tb_command_line_parser;

  localparam int VB = cmdp_pkg::VALUE_BITS_DEF;

  typedef enum logic [3:0] {
    LP_START, LP_GOT_T, LP_GOT_R, LP_GOT_S, LP_WAIT_N1, LP_IN_N1, LP_WAIT_N2,
    LP_IN_N2, LP_WAIT_DIR, LP_TRAIL, LP_BAD, LP_IGNORE
  } line_phase_t;

  logic                   clk;
  logic                   rst;
  logic                   char_valid;
  logic                   char_stall;
  cmdp_pkg::char_item_t   char_item;
  logic                   result_valid;
  logic                   result_stall = 1'b0;
  cmdp_pkg::result_item_t result_item;

  command_line_parser dut (
    .clk          (clk),
    .rst          (rst),
    .char_valid   (char_valid),
    .char_stall   (char_stall),
    .char_item    (char_item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_item  (result_item)
  );

  // line predictor state
  line_phase_t                  line_phase = LP_START;
  logic [VB-1:0]                first_num = '0;
  logic [VB-1:0]                second_num = '0;
  logic                         straight_dir = 1'b0;
  logic [cmdp_pkg::USAGE_W-1:0] kind = cmdp_pkg::KIND_TR;

  cmdp_pkg::result_item_t expected_results[$];
  logic [7:0]             line_buf[$];

  int gap_pct = 0;
  int stall_pct = 0;
  int stall_left = 0;
  int items_sent = 0;
  int lines_sent = 0;
  int results_checked = 0;
  int mismatch_count = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("Test completed with failures");
    $finish;
  end

  function automatic logic is_digit(logic [7:0] c);
    return c >= cmdp_pkg::CH_0 && c <= cmdp_pkg::CH_9;
  endfunction

  function automatic logic is_dir_char(logic [7:0] c);
    return c == cmdp_pkg::CH_UP_S || c == cmdp_pkg::CH_S ||
           c == cmdp_pkg::CH_UP_C || c == cmdp_pkg::CH_C;
  endfunction

  function automatic logic [VB-1:0] next_decimal(logic [VB-1:0] acc, logic [7:0] c);
    logic [VB-1:0] digit;
    digit = VB'(c[3:0]);
    return VB'(acc * VB'(10) + digit);
  endfunction

  function automatic void predict_char(cmdp_pkg::char_item_t it);
    logic [7:0]             c;
    cmdp_pkg::result_item_t r;
    logic                   bad;
    c = it.char_byte;
    if (!it.is_end) begin
      case (line_phase)
        LP_START: if (c != cmdp_pkg::CH_SPACE) begin
          if (c == cmdp_pkg::CH_T) line_phase = LP_GOT_T;
          else if (c == cmdp_pkg::CH_R) line_phase = LP_GOT_R;
          else if (c == cmdp_pkg::CH_S) line_phase = LP_GOT_S;
          else if (c == cmdp_pkg::CH_Q) begin
            kind = cmdp_pkg::KIND_Q;
            line_phase = LP_TRAIL;
          end else line_phase = LP_IGNORE;
        end
        LP_GOT_T: if (c == cmdp_pkg::CH_R) begin
          kind = cmdp_pkg::KIND_TR;
          line_phase = LP_WAIT_N1;
        end else line_phase = LP_IGNORE;
        LP_GOT_R: if (c == cmdp_pkg::CH_V) begin
          kind = cmdp_pkg::KIND_RV;
          line_phase = LP_WAIT_N1;
        end else line_phase = LP_IGNORE;
        LP_GOT_S: if (c == cmdp_pkg::CH_W) begin
          kind = cmdp_pkg::KIND_SW;
          line_phase = LP_WAIT_N1;
        end else line_phase = LP_IGNORE;
        LP_WAIT_N1: if (c != cmdp_pkg::CH_SPACE) begin
          if (is_digit(c)) begin
            first_num = next_decimal('0, c);
            line_phase = LP_IN_N1;
          end else line_phase = LP_BAD;
        end
        LP_IN_N1: begin
          if (is_digit(c)) first_num = next_decimal(first_num, c);
          else if (c == cmdp_pkg::CH_SPACE) begin
            if (kind == cmdp_pkg::KIND_TR) line_phase = LP_WAIT_N2;
            else if (kind == cmdp_pkg::KIND_SW) line_phase = LP_WAIT_DIR;
            else line_phase = LP_TRAIL;
          end else if (kind == cmdp_pkg::KIND_SW && is_dir_char(c)) begin
            // direction may follow the switch number directly
            straight_dir = (c == cmdp_pkg::CH_UP_S || c == cmdp_pkg::CH_S);
            line_phase = LP_TRAIL;
          end else line_phase = LP_BAD;
        end
        LP_WAIT_N2: if (c != cmdp_pkg::CH_SPACE) begin
          if (is_digit(c)) begin
            second_num = next_decimal('0, c);
            line_phase = LP_IN_N2;
          end else line_phase = LP_BAD;
        end
        LP_IN_N2: begin
          if (is_digit(c)) second_num = next_decimal(second_num, c);
          else if (c == cmdp_pkg::CH_SPACE) line_phase = LP_TRAIL;
          else line_phase = LP_BAD;
        end
        LP_WAIT_DIR: if (c != cmdp_pkg::CH_SPACE) begin
          if (is_dir_char(c)) begin
            straight_dir = (c == cmdp_pkg::CH_UP_S || c == cmdp_pkg::CH_S);
            line_phase = LP_TRAIL;
          end else line_phase = LP_BAD;
        end
        LP_TRAIL: if (c != cmdp_pkg::CH_SPACE) line_phase = LP_BAD;
        default: ;
      endcase
    end else begin
      r = '0;
      bad = 1'b0;
      case (line_phase)
        LP_WAIT_N1, LP_WAIT_N2, LP_WAIT_DIR, LP_BAD: bad = 1'b1;
        LP_IN_N1: if (kind == cmdp_pkg::KIND_RV) begin
          r.cmd_tag = cmdp_pkg::TAG_REV;
          r.first_value = cmdp_pkg::OUT_W'(first_num);
        end else bad = 1'b1;
        LP_IN_N2: begin
          r.cmd_tag = cmdp_pkg::TAG_SPEED;
          r.first_value = cmdp_pkg::OUT_W'(first_num);
          r.second_value = cmdp_pkg::OUT_W'(second_num);
        end
        LP_TRAIL: begin
          if (kind == cmdp_pkg::KIND_TR) begin
            r.cmd_tag = cmdp_pkg::TAG_SPEED;
            r.first_value = cmdp_pkg::OUT_W'(first_num);
            r.second_value = cmdp_pkg::OUT_W'(second_num);
          end else if (kind == cmdp_pkg::KIND_RV) begin
            r.cmd_tag = cmdp_pkg::TAG_REV;
            r.first_value = cmdp_pkg::OUT_W'(first_num);
          end else if (kind == cmdp_pkg::KIND_SW) begin
            r.cmd_tag = cmdp_pkg::TAG_SWITCH;
            r.first_value = cmdp_pkg::OUT_W'(first_num);
            r.straight = straight_dir;
          end else r.cmd_tag = cmdp_pkg::TAG_QUIT;
        end
        default: ;
      endcase
      if (bad) begin
        r.cmd_tag = cmdp_pkg::TAG_INVALID;
        r.usage_code = kind;
      end
      expected_results.push_back(r);
      line_phase = LP_START;
      first_num = '0;
      second_num = '0;
      straight_dir = 1'b0;
      kind = cmdp_pkg::KIND_TR;
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s at %0t: got %0h, expected %0h", what, $realtime, got, want);
    mismatch_count++;
  endtask

  // one character or end marker per transfer, with random idle bursts before it
  task automatic send_char(input cmdp_pkg::char_item_t it);
    int gap;
    @(negedge clk);
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      gap = $urandom_range(1, 18);
      char_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    char_valid <= 1'b1;
    char_item <= it;
    do @(posedge clk); while (char_stall);
    predict_char(it);
    items_sent++;
  endtask

  task automatic send_line();
    cmdp_pkg::char_item_t it;
    foreach (line_buf[i]) begin
      it.char_byte = line_buf[i];
      it.is_end = 1'b0;
      send_char(it);
    end
    // the byte that rides with the end marker is don't-care, so randomize it
    it.char_byte = 8'($urandom_range(0, 255));
    it.is_end = 1'b1;
    send_char(it);
    line_buf.delete();
    lines_sent++;
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endtask

  task automatic send_text(input string s);
    add_text(s);
    send_line();
  endtask

  task automatic add_spaces(input int lo, input int hi);
    repeat ($urandom_range(lo, hi)) line_buf.push_back(cmdp_pkg::CH_SPACE);
  endtask

  task automatic add_number();
    int ndig;
    ndig = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 14) : $urandom_range(1, 4);
    repeat (ndig) line_buf.push_back(8'(cmdp_pkg::CH_0 + $urandom_range(0, 9)));
  endtask

  task automatic add_good_line();
    logic [7:0] dirs[4];
    dirs = '{cmdp_pkg::CH_UP_S, cmdp_pkg::CH_S, cmdp_pkg::CH_UP_C, cmdp_pkg::CH_C};
    add_spaces(0, 3);
    case ($urandom_range(0, 3))
      0: begin
        add_text("tr");
        add_spaces(0, 2);
        add_number();
        add_spaces(1, 2);
        add_number();
      end
      1: begin
        add_text("rv");
        add_spaces(0, 2);
        add_number();
      end
      2: begin
        add_text("sw");
        add_spaces(0, 2);
        add_number();
        add_spaces(0, 2);
        line_buf.push_back(dirs[$urandom_range(0, 3)]);
      end
      default: add_text("q");
    endcase
    add_spaces(0, 2);
  endtask

  // mostly well-formed lines with random content, the rest broken or plain noise
  task automatic test_random_lines(input int n_items, input int gap, input int stall);
    int stop_at;
    int idx;
    int pick;
    logic [7:0] junk;
    gap_pct = gap;
    stall_pct = stall;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        repeat ($urandom_range(0, 8))
          line_buf.push_back(($urandom_range(0, 3) == 0) ?
                             cmdp_pkg::CH_SPACE : 8'($urandom_range(0, 255)));
      end else begin
        add_good_line();
        if (pick < 35 && line_buf.size() > 0) begin
          idx = $urandom_range(0, line_buf.size() - 1);
          junk = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 255)) :
                                               8'($urandom_range(32, 126));
          case ($urandom_range(0, 2))
            0: while (line_buf.size() > idx) void'(line_buf.pop_back());
            1: line_buf[idx] = junk;
            default: line_buf.insert(idx, junk);
          endcase
        end
      end
      send_line();
    end
  endtask

  task automatic test_blank_and_unknown();
    send_text("");
    send_text("    ");
    send_text("x");
    send_text("  Q");
    // a lone or mismatched command letter gives none
    send_text("t");
    send_text("tx");
    send_text("r");
    send_text("s ");
  endtask

  task automatic test_well_formed();
    send_text("tr 4294967295 4294967295");
    send_text("rv 0");
    send_text("  sw 7 S  ");
    send_text("sw 12c");
    send_text("sw 3   C");
    send_text("sw9s");
    send_text("q");
    send_text("  q  ");
  endtask

  task automatic test_malformed();
    // digits run together stay in the first number
    send_text("tr 123");
    send_text("tr 1 ");
    send_text("tr 1 2x");
    send_text("rv");
    send_text("rv 5 7");
    send_text("sw 4");
    send_text("sw 4 x");
    send_text("q x");
  endtask

  task automatic test_number_wrap();
    send_text("tr 99999999999 18446744073709551617");
    send_text("rv 4294967296");
  endtask

  // receiver stall bursts
  always @(negedge clk) begin
    if (rst || stall_pct == 0) begin
      stall_left = 0;
      result_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      result_stall <= 1'b1;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      stall_left = $urandom_range(1, 18) - 1;
      result_stall <= 1'b1;
    end else begin
      result_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin : result_check
    cmdp_pkg::result_item_t want;
    if (!rst && result_valid && !result_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with no line pending", 32'(result_item.cmd_tag), '0);
      end else begin
        want = expected_results.pop_front();
        if (result_item.cmd_tag !== want.cmd_tag)
          report_mismatch("cmd_tag", 32'(result_item.cmd_tag), 32'(want.cmd_tag));
        if (result_item.usage_code !== want.usage_code)
          report_mismatch("usage_code", 32'(result_item.usage_code),
                          32'(want.usage_code));
        if (result_item.first_value !== want.first_value)
          report_mismatch("first_value", result_item.first_value, want.first_value);
        if (result_item.second_value !== want.second_value)
          report_mismatch("second_value", result_item.second_value, want.second_value);
        if (result_item.straight !== want.straight)
          report_mismatch("straight", 32'(result_item.straight), 32'(want.straight));
        results_checked++;
      end
    end
  end

  initial begin
    rst = 1'b1;
    char_valid = 1'b0;
    char_item = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_blank_and_unknown();
    test_well_formed();
    test_malformed();
    test_number_wrap();
    test_random_lines(320, 25, 25);
    test_random_lines(320, 8, 40);
    // closing stretch with no idling on either side
    test_random_lines(120, 0, 0);

    @(negedge clk);
    char_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (expected_results.size() != 0) begin
      report_mismatch("results never arrived", 32'(expected_results.size()), '0);
    end

    $display("covered %0d lines in %0d character transfers, %0d results checked",
             lines_sent, items_sent, results_checked);
    $display("random idle and stall bursts on both channels, then a stretch at full rate");
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
